### hdl/cfc_pkg.sv
// Shared types, codes and helper functions for the command frame checker.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package cfc_pkg;

    // frame layout
    localparam int HDR_BYTES = 5;
    localparam int CRC_BYTES = 2;
    localparam int CMD_BYTES = 7;

    localparam logic [7:0] VERSION_CODE = 8'd2;
    localparam logic [7:0] TYPE_CMD     = 8'd1;
    localparam logic [7:0] TYPE_PING    = 8'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_VER  = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_BAD_CRC  = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE = 3'd4;

    // CRC16-CCITT, MSB first
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic signed [7:0] PCT_MIN = -8'sd100;
    localparam logic signed [7:0] PCT_MAX = 8'sd100;

    // one received byte as held in the input register
    typedef struct packed {
        logic       kind;
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_item;

    // one frame verdict
    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        seq_echo;
        logic              has_command;
        logic signed [7:0] throttle;
        logic signed [7:0] rudder;
        logic [7:0]        accessory_a;
        logic [7:0]        accessory_b;
        logic [7:0]        accessory_c;
        logic [7:0]        accessory_d;
        logic [7:0]        arm_byte;
        logic [15:0]       good_count;
        logic [15:0]       bad_count;
    } t_result;

    // fold one byte into the CRC, eight bit steps unrolled
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // limit a two's complement percent byte to the legal range
    function automatic logic signed [7:0] clamp_pct(input logic [7:0] raw);
        logic signed [7:0] v;
        v = signed'(raw);
        if (v < PCT_MIN) begin
            v = PCT_MIN;
        end else if (v > PCT_MAX) begin
            v = PCT_MAX;
        end
        return v;
    endfunction

endpackage

### hdl/cfc_in_reg.sv
// Input register of the command frame checker: holds one byte transfer.
// Depends on cfc_pkg for the item type.
`timescale 1ns / 1ps

module cfc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_kind,
    input  logic [7:0]     i_frame_byte,
    input  logic           i_last_byte,
    input  logic           i_go,
    output logic           o_valid,
    output cfc_pkg::t_item o_item
);
    import cfc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    // stall only while the held byte cannot move on
    assign o_stall = r_valid && !i_go;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // capture payload on transfer
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.kind       <= i_kind;
            r_item.frame_byte <= i_frame_byte;
            r_item.last_byte  <= i_last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hdl/cfc_frame_check.sv
// Frame state, CRC update and end-of-frame checks for the command frame checker.
// Depends on cfc_pkg for codes, types, crc_feed and clamp_pct.
`timescale 1ns / 1ps

module cfc_frame_check #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cfc_pkg::t_item   i_item,
    input  logic             i_out_free,
    output logic             o_go,
    output logic             o_res_valid,
    output cfc_pkg::t_result o_res
);
    import cfc_pkg::*;

    localparam int              PW       = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [PW-1:0]   POS_MAX  = PW'(MAX_FRAME_BYTES);
    localparam logic [PW-1:0]   POS_MIN  = PW'(HDR_BYTES + CRC_BYTES);
    localparam logic [PW-1:0]   CMD_LO   = PW'(HDR_BYTES);
    localparam logic [PW-1:0]   CMD_HI   = PW'(HDR_BYTES + CMD_BYTES);
    localparam logic [7:0]      LEN_MAX  = 8'(MAX_FRAME_BYTES - HDR_BYTES - CRC_BYTES);
    localparam logic [7:0]      LEN_CMD  = 8'(CMD_BYTES);
    localparam int              CIW      = $clog2(CMD_BYTES);

    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_crc, n_crc;
    logic          r_ver_good, n_ver_good;
    logic [7:0]    r_seq, n_seq;
    logic [7:0]    r_type, n_type;
    logic [7:0]    r_len, n_len;
    logic [15:0]   r_rx_crc, n_rx_crc;
    logic [15:0]   r_good, n_good;
    logic [15:0]   r_bad, n_bad;
    logic [7:0]    r_cmd [CMD_BYTES];

    logic          produces;
    logic          in_room;
    logic          cmd_we;
    logic [CIW-1:0] cmd_idx;
    logic          clear;

    assign produces = i_item.kind || i_item.last_byte;
    assign in_room  = (r_pos <= POS_MAX);
    assign o_go     = i_valid && (i_out_free || !produces);
    assign o_res_valid = o_go && produces;

    // command payload bytes sit at positions five to eleven
    assign cmd_we  = o_go && !i_item.kind && in_room && (r_pos >= CMD_LO) && (r_pos < CMD_HI);
    assign cmd_idx = CIW'(r_pos - CMD_LO);

    // next frame state and verdict
    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_ver_good = r_ver_good;
        n_seq      = r_seq;
        n_type     = r_type;
        n_len      = r_len;
        n_rx_crc   = r_rx_crc;
        n_good     = r_good;
        n_bad      = r_bad;
        clear      = 1'b0;
        o_res      = '0;

        if (i_item.kind) begin
            // empty frame notice drops any partial frame
            n_bad          = r_bad + 16'd1;
            o_res.status   = ST_BAD_LEN;
            clear          = 1'b1;
        end else begin
            if (in_room) begin
                if (r_pos == PW'(0)) begin
                    n_ver_good = (i_item.frame_byte == VERSION_CODE);
                end else if (r_pos == PW'(1)) begin
                    n_type = i_item.frame_byte;
                end else if (r_pos == PW'(3)) begin
                    n_seq = i_item.frame_byte;
                end else if (r_pos == PW'(4)) begin
                    n_len = i_item.frame_byte;
                end
                // CRC trails two bytes behind so the trailer is never folded in
                if (r_pos >= PW'(2)) begin
                    n_crc = crc_feed(r_crc, r_rx_crc[7:0]);
                end
                n_rx_crc = {i_item.frame_byte, r_rx_crc[15:8]};
                n_pos    = r_pos + PW'(1);
            end

            if (i_item.last_byte) begin
                clear = 1'b1;
                if (n_pos > POS_MAX || n_pos < POS_MIN) begin
                    n_bad        = r_bad + 16'd1;
                    o_res.status = ST_BAD_LEN;
                end else begin
                    o_res.seq_echo = n_seq;
                    if (!n_ver_good) begin
                        n_bad        = r_bad + 16'd1;
                        o_res.status = ST_BAD_VER;
                    end else if (({1'b0, n_len} + 9'(HDR_BYTES + CRC_BYTES)) != 9'(n_pos)
                                 || n_len > LEN_MAX) begin
                        n_bad        = r_bad + 16'd1;
                        o_res.status = ST_BAD_LEN;
                    end else if (n_rx_crc != n_crc) begin
                        n_bad        = r_bad + 16'd1;
                        o_res.status = ST_BAD_CRC;
                    end else begin
                        n_good = r_good + 16'd1;
                        if (n_type == TYPE_CMD) begin
                            if (n_len != LEN_CMD) begin
                                o_res.status = ST_BAD_LEN;
                            end else begin
                                o_res.status      = ST_OK;
                                o_res.has_command = 1'b1;
                                o_res.throttle    = clamp_pct(r_cmd[0]);
                                o_res.rudder      = clamp_pct(r_cmd[1]);
                                o_res.accessory_a = r_cmd[2];
                                o_res.accessory_b = r_cmd[3];
                                o_res.accessory_c = r_cmd[4];
                                o_res.accessory_d = r_cmd[5];
                                o_res.arm_byte    = r_cmd[6];
                            end
                        end else if (n_type == TYPE_PING) begin
                            o_res.status = ST_OK;
                        end else begin
                            o_res.status = ST_BAD_TYPE;
                        end
                    end
                end
            end
        end

        o_res.good_count = n_good;
        o_res.bad_count  = n_bad;

        // restart framing after a verdict
        if (clear) begin
            n_pos      = '0;
            n_crc      = CRC_INIT;
            n_ver_good = 1'b0;
            n_seq      = '0;
            n_type     = '0;
            n_len      = '0;
            n_rx_crc   = '0;
        end
    end

    // advance frame state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_crc      <= CRC_INIT;
            r_ver_good <= 1'b0;
            r_seq      <= '0;
            r_type     <= '0;
            r_len      <= '0;
            r_rx_crc   <= '0;
            r_good     <= '0;
            r_bad      <= '0;
        end else if (o_go) begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_ver_good <= n_ver_good;
            r_seq      <= n_seq;
            r_type     <= n_type;
            r_len      <= n_len;
            r_rx_crc   <= n_rx_crc;
            r_good     <= n_good;
            r_bad      <= n_bad;
        end
    end

    // capture command payload bytes
    always_ff @(posedge i_clk) begin
        if (cmd_we) begin
            r_cmd[cmd_idx] <= i_item.frame_byte;
        end
    end

    // position saturates one past the limit
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX + PW'(1))
        else $error("byte position past saturation point");

    // a verdict always restarts the frame
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == '0 && r_crc == CRC_INIT && !r_ver_good))
        else $error("frame state not cleared after verdict");

    // each verdict moves exactly one of the two counters by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (16'(r_good + r_bad) == 16'($past(r_good) + $past(r_bad) + 16'd1)))
        else $error("frame counters out of step with verdicts");

    // bytes that give no verdict leave the counters alone
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_go && !produces) |=> ($stable(r_good) && $stable(r_bad)))
        else $error("counter moved without a verdict");

endmodule

### hdl/cfc_out_reg.sv
// Result register of the command frame checker: holds one verdict for transfer.
// Depends on cfc_pkg for the result type.
`timescale 1ns / 1ps

module cfc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cfc_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output cfc_pkg::t_result o_res
);
    import cfc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // slot can take a new verdict when empty or draining this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // hold verdict until transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hdl/command_frame_checker_top.sv
// Top level of the command frame checker: input register, frame checks, result register.
// Depends on cfc_pkg, cfc_in_reg, cfc_frame_check and cfc_out_reg.
//
//   channel   direction  handshake          payload
//   byte in   input      i_valid / o_stall  i_kind, i_frame_byte, i_last_byte
//   verdict   output     o_valid / i_stall  o_status ... o_bad_count
//
// One byte per cycle sustained; a verdict is formed from the input register and held in
// the result register. The CRC fold of one byte and the end-of-frame checks
// share one cycle. Synchronous active-low reset clears framing state,
// counters and both valid flags. A stalled verdict backs up into the input register only
// for bytes that end a frame; mid-frame bytes keep flowing while a verdict waits.
`timescale 1ns / 1ps

module command_frame_checker_top #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_kind,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_last_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_status,
    output logic [7:0]        o_seq_echo,
    output logic              o_has_command,
    output logic signed [7:0] o_throttle,
    output logic signed [7:0] o_rudder,
    output logic [7:0]        o_accessory_a,
    output logic [7:0]        o_accessory_b,
    output logic [7:0]        o_accessory_c,
    output logic [7:0]        o_accessory_d,
    output logic [7:0]        o_arm_byte,
    output logic [15:0]       o_good_count,
    output logic [15:0]       o_bad_count
);
    import cfc_pkg::*;

    logic    s1_valid;
    t_item   s1_item;
    logic    s1_go;
    logic    res_valid;
    t_result res;
    logic    out_free;
    t_result out_res;

    cfc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .i_go         (s1_go),
        .o_valid      (s1_valid),
        .o_item       (s1_item)
    );

    cfc_frame_check #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_item      (s1_item),
        .i_out_free  (out_free),
        .o_go        (s1_go),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cfc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    // unpack verdict onto ports
    assign o_status      = out_res.status;
    assign o_seq_echo    = out_res.seq_echo;
    assign o_has_command = out_res.has_command;
    assign o_throttle    = out_res.throttle;
    assign o_rudder      = out_res.rudder;
    assign o_accessory_a = out_res.accessory_a;
    assign o_accessory_b = out_res.accessory_b;
    assign o_accessory_c = out_res.accessory_c;
    assign o_accessory_d = out_res.accessory_d;
    assign o_arm_byte    = out_res.arm_byte;
    assign o_good_count  = out_res.good_count;
    assign o_bad_count   = out_res.bad_count;

endmodule

### bench/command_frame_checker_top_test.sv
// Self-checking testbench for command_frame_checker_top: drives received bytes,
// predicts each frame verdict and compares it field by field.
// Depends on cfc_pkg and the RTL of command_frame_checker_top.
`timescale 1ns / 1ps

module command_frame_checker_top_test;
    import cfc_pkg::*;

    localparam int FRAME_MAX      = 32;
    localparam int TARGET_BYTES   = 900;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    // Tracks framing state, counters and the queue of verdicts still to arrive.
    class frame_verdict_tracker;
        int        max_bytes;
        int        errors;
        t_result   verdicts_due[$];
        bit [5:0]  byte_pos;
        bit [15:0] crc_run;
        bit        version_ok;
        bit [7:0]  seq_byte;
        bit [7:0]  type_byte;
        bit [7:0]  len_byte;
        bit [15:0] crc_tail;
        bit [7:0]  cmd_bytes[CMD_BYTES];
        bit [15:0] good_frames;
        bit [15:0] bad_frames;

        function new(int max_frame);
            max_bytes   = max_frame;
            errors      = 0;
            good_frames = '0;
            bad_frames  = '0;
            foreach (cmd_bytes[i]) cmd_bytes[i] = '0;
            restart_frame();
        endfunction

        function void restart_frame();
            byte_pos   = '0;
            crc_run    = CRC_INIT;
            version_ok = 1'b0;
            seq_byte   = '0;
            type_byte  = '0;
            len_byte   = '0;
            crc_tail   = '0;
        endfunction

        // CRC16-CCITT, one data bit at a time, MSB first
        static function bit [15:0] crc_step(bit [15:0] crc, bit [7:0] data);
            bit [15:0] c;
            bit        fb;
            c = crc;
            for (int k = 7; k >= 0; k--) begin
                fb = c[15] ^ data[k];
                c  = c << 1;
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        static function bit [7:0] limit_pct(bit [7:0] raw);
            int v;
            v = int'($signed(raw));
            if (v < int'(PCT_MIN)) v = int'(PCT_MIN);
            if (v > int'(PCT_MAX)) v = int'(PCT_MAX);
            return v[7:0];
        endfunction

        // Queue one verdict and drop the frame state
        function void post(bit [2:0] st, bit [7:0] seq, bit with_cmd);
            t_result r;
            r = '0;
            r.status      = st;
            r.seq_echo    = seq;
            r.has_command = with_cmd;
            if (with_cmd) begin
                r.throttle    = limit_pct(cmd_bytes[0]);
                r.rudder      = limit_pct(cmd_bytes[1]);
                r.accessory_a = cmd_bytes[2];
                r.accessory_b = cmd_bytes[3];
                r.accessory_c = cmd_bytes[4];
                r.accessory_d = cmd_bytes[5];
                r.arm_byte    = cmd_bytes[6];
            end
            r.good_count = good_frames;
            r.bad_count  = bad_frames;
            verdicts_due.push_back(r);
            restart_frame();
        endfunction

        // Advance the framing state by one accepted transfer
        function void take_byte(bit kind, bit [7:0] b, bit last);
            int       n;
            bit [2:0] st;
            if (kind) begin
                bad_frames++;
                post(ST_BAD_LEN, 8'h00, 1'b0);
                return;
            end
            if (byte_pos <= max_bytes) begin
                case (byte_pos)
                    0: version_ok = (b == VERSION_CODE);
                    1: type_byte = b;
                    3: seq_byte = b;
                    4: len_byte = b;
                    default: begin
                        if (byte_pos >= HDR_BYTES && byte_pos < HDR_BYTES + CMD_BYTES) begin
                            cmd_bytes[byte_pos - HDR_BYTES] = b;
                        end
                    end
                endcase
                // the trailing two bytes are the CRC itself, so fold with a lag of two
                if (byte_pos >= 2) begin
                    crc_run = crc_step(crc_run, crc_tail[7:0]);
                end
                crc_tail = {b, crc_tail[15:8]};
                byte_pos++;
            end
            if (!last) return;

            n = int'(byte_pos);
            if (n > max_bytes || n < HDR_BYTES + CRC_BYTES) begin
                bad_frames++;
                post(ST_BAD_LEN, 8'h00, 1'b0);
                return;
            end
            if (!version_ok) begin
                st = ST_BAD_VER;
            end else if (HDR_BYTES + int'(len_byte) + CRC_BYTES != n) begin
                st = ST_BAD_LEN;
            end else if (int'(len_byte) > max_bytes - HDR_BYTES - CRC_BYTES) begin
                st = ST_BAD_LEN;
            end else if (crc_tail != crc_run) begin
                st = ST_BAD_CRC;
            end else begin
                st = ST_OK;
            end
            if (st != ST_OK) begin
                bad_frames++;
                post(st, seq_byte, 1'b0);
                return;
            end
            // framing passed: count it, then judge the type
            good_frames++;
            if (type_byte == TYPE_CMD) begin
                if (len_byte != CMD_BYTES) begin
                    post(ST_BAD_LEN, seq_byte, 1'b0);
                end else begin
                    post(ST_OK, seq_byte, 1'b1);
                end
            end else if (type_byte == TYPE_PING) begin
                post(ST_OK, seq_byte, 1'b0);
            end else begin
                post(ST_BAD_TYPE, seq_byte, 1'b0);
            end
        endfunction

        function void match_field(string what, int want_v, int got_v);
            if (want_v != got_v) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
                errors++;
            end
        endfunction

        // Compare one accepted verdict with the oldest prediction
        function void compare_verdict(t_result got);
            t_result want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict, status %0d seq %0d", $time,
                         got.status, got.seq_echo);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            match_field("status", want.status, got.status);
            match_field("seq_echo", want.seq_echo, got.seq_echo);
            match_field("has_command", want.has_command, got.has_command);
            match_field("throttle", int'(want.throttle), int'(got.throttle));
            match_field("rudder", int'(want.rudder), int'(got.rudder));
            match_field("accessory_a", want.accessory_a, got.accessory_a);
            match_field("accessory_b", want.accessory_b, got.accessory_b);
            match_field("accessory_c", want.accessory_c, got.accessory_c);
            match_field("accessory_d", want.accessory_d, got.accessory_d);
            match_field("arm_byte", want.arm_byte, got.arm_byte);
            match_field("good_count", want.good_count, got.good_count);
            match_field("bad_count", want.bad_count, got.bad_count);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_kind;
    logic [7:0]        i_frame_byte;
    logic              i_last_byte;
    logic              o_valid;
    logic              i_stall;
    logic [2:0]        o_status;
    logic [7:0]        o_seq_echo;
    logic              o_has_command;
    logic signed [7:0] o_throttle;
    logic signed [7:0] o_rudder;
    logic [7:0]        o_accessory_a;
    logic [7:0]        o_accessory_b;
    logic [7:0]        o_accessory_c;
    logic [7:0]        o_accessory_d;
    logic [7:0]        o_arm_byte;
    logic [15:0]       o_good_count;
    logic [15:0]       o_bad_count;

    frame_verdict_tracker tracker = new(FRAME_MAX);
    bit [7:0] frm[$];
    int       bytes_sent  = 0;
    int       quiet_cycles = 0;
    bit       rush    = 1'b0;
    bit       calm    = 1'b0;
    bit       hold_off = 1'b0;

    command_frame_checker_top #(
        .MAX_FRAME_BYTES(FRAME_MAX)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_seq_echo   (o_seq_echo),
        .o_has_command(o_has_command),
        .o_throttle   (o_throttle),
        .o_rudder     (o_rudder),
        .o_accessory_a(o_accessory_a),
        .o_accessory_b(o_accessory_b),
        .o_accessory_c(o_accessory_c),
        .o_accessory_d(o_accessory_d),
        .o_arm_byte   (o_arm_byte),
        .o_good_count (o_good_count),
        .o_bad_count  (o_bad_count)
    );

    always #1 i_clk = ~i_clk;

    // Sample both channels, track transfers and watch for a hang
    always @(posedge i_clk) begin : sample_transfers
        t_result got;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            tracker.take_byte(i_kind, i_frame_byte, i_last_byte);
            moved = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got.status      = o_status;
            got.seq_echo    = o_seq_echo;
            got.has_command = o_has_command;
            got.throttle    = o_throttle;
            got.rudder      = o_rudder;
            got.accessory_a = o_accessory_a;
            got.accessory_b = o_accessory_b;
            got.accessory_c = o_accessory_c;
            got.accessory_d = o_accessory_d;
            got.arm_byte    = o_arm_byte;
            got.good_count  = o_good_count;
            got.bad_count   = o_bad_count;
            tracker.compare_verdict(got);
            moved = 1'b1;
        end
        if (!i_rst_n || moved) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request, none while calm
    initial begin : verdict_sink
        bit stall_now;
        int span;
        int r;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (hold_off) begin
                stall_now = 1'b1;
                span      = HOLD_CYCLES;
                hold_off  = 1'b0;
            end else if (calm) begin
                stall_now = 1'b0;
                span      = 1;
            end else if (r < 35) begin
                stall_now = 1'b1;
                r = $urandom_range(0, 99);
                span = (r < 80) ? $urandom_range(1, 3) :
                       (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
            end else begin
                stall_now = 1'b0;
                span      = $urandom_range(1, 10);
            end
            i_stall <= stall_now;
            repeat (span) @(negedge i_clk);
        end
    end

    // Offer one byte after a random gap; entered and left at a falling edge
    task automatic send_byte(input bit kind, input bit [7:0] b, input bit last);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (rush || calm) begin
            gap = 0;
        end else begin
            gap = (r < 60) ? 0 :
                  (r < 90) ? $urandom_range(1, 3) :
                  (r < 98) ? $urandom_range(4, 10) : $urandom_range(20, 50);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_frame_byte <= b;
        i_last_byte  <= last;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Build header and random payload; flags byte is random
    task automatic make_frame(input bit [7:0] ver, input bit [7:0] ftype,
                              input bit [7:0] seq, input int plen);
        frm = {};
        frm.push_back(ver);
        frm.push_back(ftype);
        frm.push_back(8'($urandom));
        frm.push_back(seq);
        frm.push_back(plen[7:0]);
        repeat (plen) frm.push_back(8'($urandom));
    endtask

    // Append the little-endian CRC over everything so far
    task automatic seal_frame();
        bit [15:0] c;
        c = CRC_INIT;
        foreach (frm[i]) c = frame_verdict_tracker::crc_step(c, frm[i]);
        frm.push_back(c[7:0]);
        frm.push_back(c[15:8]);
    endtask

    task automatic send_frame();
        foreach (frm[i]) send_byte(1'b0, frm[i], i == frm.size() - 1);
    endtask

    // Percent byte, biased toward the clamp boundaries
    function automatic bit [7:0] pick_pct();
        bit [7:0] edges[8] = '{8'h80, 8'h7F, 8'h9B, 8'h9C, 8'h64, 8'h65, 8'h00, 8'hFF};
        if ($urandom_range(0, 99) < 30) return edges[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    initial begin : stimulus
        int       r;
        int       cut;
        int       idx;
        int       plen;
        int       frame_no;
        bit [7:0] ftype;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = 1'b0;
        i_frame_byte = '0;
        i_last_byte  = 1'b0;
        i_stall      = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty notice with stray byte fields
        send_byte(1'b1, 8'hFF, 1'b0);
        // smallest ping
        make_frame(VERSION_CODE, TYPE_PING, 8'h00, 0);
        seal_frame();
        send_frame();
        // commands around the clamp limits
        make_frame(VERSION_CODE, TYPE_CMD, 8'hFF, CMD_BYTES);
        frm[5] = 8'h80;
        frm[6] = 8'h7F;
        seal_frame();
        send_frame();
        make_frame(VERSION_CODE, TYPE_CMD, 8'h5A, CMD_BYTES);
        frm[5] = 8'h9B;
        frm[6] = 8'h65;
        for (idx = 7; idx < 12; idx++) frm[idx] = 8'hFF;
        seal_frame();
        send_frame();
        make_frame(VERSION_CODE, TYPE_CMD, 8'hA5, CMD_BYTES);
        frm[5] = 8'h9C;
        frm[6] = 8'h64;
        for (idx = 7; idx < 12; idx++) frm[idx] = 8'h00;
        seal_frame();
        send_frame();
        // command with the wrong payload length
        make_frame(VERSION_CODE, TYPE_CMD, 8'h11, 3);
        seal_frame();
        send_frame();
        // unknown types
        make_frame(VERSION_CODE, 8'hFF, 8'h22, 1);
        seal_frame();
        send_frame();
        make_frame(VERSION_CODE, 8'h00, 8'h23, 0);
        seal_frame();
        send_frame();
        // wrong version
        make_frame(8'h00, TYPE_PING, 8'h33, 0);
        seal_frame();
        send_frame();
        make_frame(8'hFF, TYPE_CMD, 8'h34, CMD_BYTES);
        seal_frame();
        send_frame();
        // length field disagrees with the frame size
        make_frame(VERSION_CODE, TYPE_PING, 8'h44, 2);
        frm[4] = 8'd5;
        seal_frame();
        send_frame();
        // CRC mismatch
        make_frame(VERSION_CODE, TYPE_PING, 8'h55, 1);
        seal_frame();
        frm[frm.size() - 1] ^= 8'h01;
        send_frame();
        // too short
        make_frame(VERSION_CODE, TYPE_PING, 8'h66, 0);
        frm.push_back(8'h00);
        send_frame();
        // longest legal frame, then one past the limit
        make_frame(VERSION_CODE, TYPE_PING, 8'h77, FRAME_MAX - HDR_BYTES - CRC_BYTES);
        seal_frame();
        send_frame();
        make_frame(VERSION_CODE, TYPE_PING, 8'h78, FRAME_MAX - HDR_BYTES - CRC_BYTES + 1);
        seal_frame();
        send_frame();
        // partial frame cut off by an empty notice
        make_frame(VERSION_CODE, TYPE_CMD, 8'h88, CMD_BYTES);
        for (idx = 0; idx < 4; idx++) send_byte(1'b0, frm[idx], 1'b0);
        send_byte(1'b1, 8'h00, 1'b1);

        // Random frames: mostly well formed, the rest broken in varied ways
        frame_no = 0;
        while (bytes_sent < TARGET_BYTES) begin
            frame_no++;

            // fill the block while the receiver holds off
            if (frame_no == 25) begin
                hold_off = 1'b1;
                wait (hold_off == 1'b0);
                rush = 1'b1;
                repeat (12) begin
                    make_frame(VERSION_CODE, TYPE_PING, 8'($urandom), $urandom_range(0, 2));
                    seal_frame();
                    send_frame();
                end
                rush = 1'b0;
            end
            calm = (frame_no >= 40 && frame_no < 55);

            r = $urandom_range(0, 99);
            ftype = (r < 45) ? TYPE_CMD : (r < 80) ? TYPE_PING : 8'($urandom);
            if (ftype == TYPE_CMD && $urandom_range(0, 99) < 85) begin
                plen = CMD_BYTES;
            end else if ($urandom_range(0, 99) < 85) begin
                plen = $urandom_range(0, 8);
            end else begin
                plen = $urandom_range(0, FRAME_MAX - HDR_BYTES - CRC_BYTES);
            end
            make_frame(VERSION_CODE, ftype, 8'($urandom), plen);
            if (plen >= 2) begin
                frm[5] = pick_pct();
                frm[6] = pick_pct();
            end

            r = $urandom_range(0, 99);
            if (r < 4) begin
                // length field overwritten
                frm[4] = 8'($urandom);
                seal_frame();
            end else begin
                seal_frame();
            end
            if (r >= 70 && r < 76) begin
                idx = $urandom_range(0, frm.size() - 1);
                frm[idx] ^= 8'(1 << $urandom_range(0, 7));
            end else if (r >= 76 && r < 80) begin
                frm[0] = $urandom_range(0, 1) ? 8'($urandom_range(3, 255)) :
                                                8'($urandom_range(0, 1));
            end else if (r >= 80 && r < 84) begin
                idx = $urandom_range(HDR_BYTES, frm.size() - 1);
                if ($urandom_range(0, 1)) frm.delete(idx);
                else frm.insert(idx, 8'($urandom));
            end else if (r >= 84 && r < 88) begin
                cut = $urandom_range(1, HDR_BYTES + CRC_BYTES - 1);
                while (frm.size() > cut) void'(frm.pop_back());
            end else if (r >= 88 && r < 92) begin
                cut = $urandom_range(FRAME_MAX + 1, FRAME_MAX + 13);
                while (frm.size() < cut) frm.push_back(8'($urandom));
            end

            if (r >= 92 && r < 96) begin
                // abort part way with an empty notice
                cut = $urandom_range(0, frm.size() - 1);
                for (idx = 0; idx < cut; idx++) send_byte(1'b0, frm[idx], 1'b0);
                send_byte(1'b1, 8'($urandom), 1'($urandom));
            end else begin
                send_frame();
            end
            if ($urandom_range(0, 99) < 3) begin
                send_byte(1'b1, 8'($urandom), 1'($urandom));
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // Drain outstanding verdicts, then allow the pipeline to settle
        while (tracker.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.verdicts_due.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, tracker.verdicts_due.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
